FILE: hdl/ttfr_pkg.sv
// Package for the three-type frame receiver.
// Holds byte codes, result codes, register indexes, reset values and shared types.
// No dependencies.
package ttfr_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int MAX_RESULTS   = 62;

  localparam logic [7:0] CH_OPEN_PCT   = 8'h25; // '%'
  localparam logic [7:0] CH_OPEN_PAREN = 8'h28; // '('
  localparam logic [7:0] CH_OPEN_DLR   = 8'h24; // '$'
  localparam logic [7:0] CH_END_HASH   = 8'h23; // '#'
  localparam logic [7:0] CH_STAR       = 8'h2A; // '*'
  localparam logic [7:0] CH_END_PAREN  = 8'h29; // ')'

  localparam logic [1:0] STAR_RUN_MAX = 2'd3;

  localparam logic [31:0] TIMEOUT_RST = 32'd5000;
  localparam logic [5:0]  TYPE1_RST   = 6'd38;
  localparam logic [5:0]  TYPE2_RST   = 6'd11;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_TYPE1   = 2'd1;
  localparam logic [1:0] CFG_TYPE2   = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] FT_NONE   = 2'd0;
  localparam logic [1:0] FT_DATA   = 2'd1;
  localparam logic [1:0] FT_HEIGHT = 2'd2;
  localparam logic [1:0] FT_SITE   = 2'd3;

  localparam logic CMD_BYTE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CHK  = 4'b0100,
    S_FIN  = 4'b1000
  } seq_state_t;

  // frame end detected on the accepted byte
  typedef struct packed {
    logic       hit;
    logic [1:0] ftype;
  } frame_end_t;

endpackage

FILE: hdl/ttfr_store.sv
// Frame byte store: one write port, one registered read port.
// Depends on nothing but its parameter.
module ttfr_store #(
  parameter int BUF_DEPTH = 64,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/ttfr_ctrl.sv
// Byte classifier and status state: frame fill, star run, permit, signal timeout.
// Also holds the configuration registers. Uses ttfr_pkg.
module ttfr_ctrl
  import ttfr_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int FW = $clog2(BUF_DEPTH + 1),
  localparam int CW = (FW > 6) ? FW : 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic          in_command,
  input  logic [7:0]    in_rx_byte,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output frame_end_t    fe,
  output logic [FW-1:0] end_cnt,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          signal_flag_r,
  output logic          permit_r
);

  logic [FW-1:0] fill_r, fill_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [1:0]    star_run_r, star_run_nxt;
  logic          permit_nxt, signal_flag_nxt;
  logic [31:0]   ticks_r, ticks_nxt;
  logic [31:0]   timeout_r;
  logic [5:0]    type1_len_r, type2_len_r;

  logic          is_open, frame_act, has_room;
  logic [1:0]    ftype;

  assign is_open   = (in_rx_byte == CH_OPEN_PCT) || (in_rx_byte == CH_OPEN_PAREN) ||
                     (in_rx_byte == CH_OPEN_DLR);
  assign frame_act = is_open || in_frame_r;
  assign has_room  = fill_r < FW'(BUF_DEPTH);

  always_comb begin
    ftype = FT_NONE;
    if (!is_open && in_frame_r) begin
      if (in_rx_byte == CH_END_HASH && CW'(fill_r) == CW'(type1_len_r)) begin
        ftype = FT_DATA;
      end else if (in_rx_byte == CH_STAR && CW'(fill_r) == CW'(type2_len_r)) begin
        ftype = FT_HEIGHT;
      end else if (in_rx_byte == CH_END_PAREN) begin
        ftype = FT_SITE;
      end
    end
  end

  assign fe.hit   = in_accept && (in_command == CMD_BYTE) && (ftype != FT_NONE);
  assign fe.ftype = ftype;
  // closing byte takes the last stored slot when the store is full
  assign end_cnt  = has_room ? fill_r : fill_r - FW'(1);

  assign wr_en   = in_accept && (in_command == CMD_BYTE) && (is_open || (in_frame_r && has_room));
  assign wr_addr = is_open ? '0 : fill_r[AW-1:0];
  assign wr_data = in_rx_byte;

  always_comb begin
    fill_nxt        = fill_r;
    in_frame_nxt    = in_frame_r;
    star_run_nxt    = star_run_r;
    permit_nxt      = permit_r;
    signal_flag_nxt = signal_flag_r;
    ticks_nxt       = ticks_r;
    if (in_accept) begin
      if (in_command != CMD_BYTE) begin
        if (ticks_r != '1) begin
          ticks_nxt = ticks_r + 32'd1;
        end
      end else begin
        if (is_open) begin
          fill_nxt     = FW'(1);
          in_frame_nxt = 1'b1;
        end else if (frame_act && has_room) begin
          fill_nxt = fill_r + FW'(1);
        end
        if (in_rx_byte == CH_STAR) begin
          if (star_run_r != STAR_RUN_MAX) begin
            star_run_nxt = star_run_r + 2'd1;
          end
          if (star_run_r >= 2'd2) begin
            permit_nxt = 1'b0;
          end
        end else begin
          star_run_nxt = 2'd0;
        end
        if (ticks_r > timeout_r) begin
          signal_flag_nxt = 1'b0;
        end
        if (ftype != FT_NONE) begin
          in_frame_nxt = 1'b0;
          if (ftype == FT_DATA) begin
            ticks_nxt       = '0;
            signal_flag_nxt = 1'b1;
          end else if (ftype == FT_SITE) begin
            permit_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      in_frame_r    <= 1'b0;
      star_run_r    <= 2'd0;
      permit_r      <= 1'b1;
      signal_flag_r <= 1'b0;
      ticks_r       <= '0;
    end else begin
      fill_r        <= fill_nxt;
      in_frame_r    <= in_frame_nxt;
      star_run_r    <= star_run_nxt;
      permit_r      <= permit_nxt;
      signal_flag_r <= signal_flag_nxt;
      ticks_r       <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      type1_len_r <= TYPE1_RST;
      type2_len_r <= TYPE2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r   <= cfg_data;
        CFG_TYPE1:   type1_len_r <= cfg_data[5:0];
        CFG_TYPE2:   type2_len_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/ttfr_seq.sv
// Readout sequencer: walks the store one byte per read/check pair, holds one
// pending byte so the last one can be marked, and owns the result register.
// Uses ttfr_pkg.
module ttfr_seq
  import ttfr_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int FW = $clog2(BUF_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  frame_end_t    fe,
  input  logic [FW-1:0] end_cnt,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  input  logic          out_stall,
  output logic          idle_free,
  output logic          out_valid_r,
  output logic [1:0]    out_kind_r,
  output logic [1:0]    out_ftype_r,
  output logic [7:0]    out_byte_r,
  output logic [5:0]    out_idx_r,
  output logic          out_last_r
);

  seq_state_t    state_r, state_nxt;
  logic [FW-1:0] idx_r, idx_nxt, end_r, end_nxt;
  logic [5:0]    n_r, n_nxt;
  logic [1:0]    ftype_r, ftype_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic [5:0]    pend_idx_r, pend_idx_nxt;
  logic          out_valid_nxt, out_last_nxt;
  logic [1:0]    out_kind_nxt, out_ftype_nxt;
  logic [7:0]    out_byte_nxt;
  logic [5:0]    out_idx_nxt;
  logic          free;

  assign free      = !out_valid_r || !out_stall;
  assign idle_free = (state_r == S_IDLE) && free;
  assign rd_addr   = idx_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    n_nxt         = n_r;
    ftype_nxt     = ftype_r;
    pend_v_nxt    = pend_v_r;
    pend_byte_nxt = pend_byte_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_ftype_nxt = out_ftype_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (fe.hit) begin
            ftype_nxt  = fe.ftype;
            end_nxt    = end_cnt;
            idx_nxt    = FW'(1);
            n_nxt      = 6'd0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_RD;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_STATUS;
            out_ftype_nxt = FT_NONE;
            out_byte_nxt  = 8'd0;
            out_idx_nxt   = 6'd0;
            out_last_nxt  = 1'b1;
          end
        end
      end
      S_RD: begin
        if (idx_r >= end_r || n_r == 6'(MAX_RESULTS)) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // a zero byte cuts the payload
        if (rd_data == 8'd0) begin
          state_nxt = S_FIN;
        end else if (!pend_v_r || free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_BYTE;
            out_ftype_nxt = ftype_r;
            out_byte_nxt  = pend_byte_r;
            out_idx_nxt   = pend_idx_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_byte_nxt = rd_data;
          pend_idx_nxt  = n_r;
          n_nxt         = n_r + 6'd1;
          idx_nxt       = idx_r + FW'(1);
          state_nxt     = S_RD;
        end
      end
      S_FIN: begin
        if (free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_v_r ? KIND_BYTE : KIND_EMPTY;
          out_ftype_nxt = ftype_r;
          out_byte_nxt  = pend_v_r ? pend_byte_r : 8'd0;
          out_idx_nxt   = pend_v_r ? pend_idx_r : 6'd0;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    end_r       <= end_nxt;
    n_r         <= n_nxt;
    ftype_r     <= ftype_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_ftype_r <= out_ftype_nxt;
    out_byte_r  <= out_byte_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

FILE: hdl/three_type_frame_receiver_top.sv
// Three-type frame receiver, top level.
// Instantiates ttfr_ctrl, ttfr_store and ttfr_seq; uses ttfr_pkg.
//
// Input channel (in_valid/in_stall): one request per byte or time tick.
// A tick, or a byte that does not close a frame, yields one status result
// (kind 0), registered in the output register in the cycle after acceptance.
// A closing byte starts a readout of the stored frame: each payload byte
// passes through a store read state and a check state, paced by the single
// read port of the frame store. An empty payload gives one kind 2 result.
// The last result of every request carries last_of_run.
// One request is worked on at a time; in_stall stays high during readout and
// while a result waits in the output register under out_stall.
// Output channel (out_valid/out_stall): results hold steady while stalled;
// a stall simply pauses the readout.
// Configuration (cfg_valid/cfg_ready): always ready; index 0 timeout ticks,
// 1 type 1 length, 2 type 2 length; other indexes are ignored.
// Reset (rst_n low, synchronous): frame closed, send allowed, no signal,
// tick count zero, registers back to 5000/38/11. The store is not cleared.
module three_type_frame_receiver_top
  import ttfr_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_frame_type,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_payload_index,
  output logic        out_last_of_run,
  output logic        out_signal_present,
  output logic        out_send_allowed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);

  logic          in_accept, idle_free;
  frame_end_t    fe;
  logic [FW-1:0] end_cnt;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle_free;
  assign in_accept = in_valid && idle_free;

  ttfr_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_command    (in_command),
    .in_rx_byte    (in_rx_byte),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fe            (fe),
    .end_cnt       (end_cnt),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .signal_flag_r (out_signal_present),
    .permit_r      (out_send_allowed)
  );

  ttfr_store #(.BUF_DEPTH(BUF_DEPTH)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  ttfr_seq #(.BUF_DEPTH(BUF_DEPTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .fe          (fe),
    .end_cnt     (end_cnt),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_stall   (out_stall),
    .idle_free   (idle_free),
    .out_valid_r (out_valid),
    .out_kind_r  (out_kind),
    .out_ftype_r (out_frame_type),
    .out_byte_r  (out_payload_byte),
    .out_idx_r   (out_payload_index),
    .out_last_r  (out_last_of_run)
  );

endmodule

FILE: hdl/ttfr_checker.sv
// Port-level checker for the three-type frame receiver, bound to the top level.
// Uses ttfr_pkg.
module ttfr_checker
  import ttfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [1:0] out_frame_type,
  input logic       out_last_of_run,
  input logic       out_signal_present,
  input logic       out_send_allowed
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // no new request while a result is stuck in the output register
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while output register blocked");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_frame_type == FT_NONE && out_last_of_run)
    else $error("status result malformed");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |-> out_frame_type != FT_NONE && out_last_of_run)
    else $error("empty frame result malformed");

  a_reset_flags: assert property (@(posedge clk)
    !rst_n |=> out_send_allowed && !out_signal_present && !out_valid)
    else $error("flags not at reset values");

endmodule

bind three_type_frame_receiver_top ttfr_checker u_ttfr_checker (.*);
